// ===== design/sgs_pkg.sv =====
// Shared types and constants for the stroke glyph sequencer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sgs_pkg;

  localparam int POINT_W       = 16;
  localparam int WIDTH_W       = 24;
  localparam int OP_W          = 8;
  localparam int REPLACE_CODE  = 63;
  localparam int RESET_ADVANCE = 8;
  localparam int WIDTH_MAX     = 8388607;
  localparam int WIDTH_MIN     = -8388608;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [OP_W-1:0] OP_END      = 8'd0;
  localparam logic [OP_W-1:0] OP_MOVE     = 8'd1;
  localparam logic [OP_W-1:0] OP_BEGIN    = 8'd2;
  localparam logic [OP_W-1:0] OP_VERTEX   = 8'd3;
  localparam logic [OP_W-1:0] OP_END_LINE = 8'd4;

  typedef enum logic [2:0] {
    EV_TRANSLATE  = 3'd0,
    EV_END_LINE   = 3'd1,
    EV_BEGIN_LINE = 3'd2,
    EV_VERTEX     = 3'd3,
    EV_DONE       = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_ENTRY,
    ST_EMIT,
    ST_CLOSE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/sgs_front.sv =====
// Front end: accepts requests, drops out-of-range loads, maps character codes
// and computes store addresses. Depends on sgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgs_front
  import sgs_pkg::*;
#(
  parameter int GLYPH_COUNT       = 128,
  parameter int ENTRIES_PER_GLYPH = 18,
  parameter int COORD_BITS        = 16,
  parameter int ADDR_W            = 12,
  parameter int QW                = 2 * COORD_BITS + ADDR_W + OP_W + 2
) (
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 command,
  input  wire logic [7:0]           char_code,
  input  wire logic [4:0]           entry_slot,
  input  wire logic [OP_W-1:0]      entry_op,
  input  wire logic signed [15:0]   entry_x,
  input  wire logic signed [15:0]   entry_y,
  input  wire logic                 start_of_string,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output logic [QW-1:0]             push_data
);

  localparam int REPL = (REPLACE_CODE < GLYPH_COUNT) ? REPLACE_CODE : GLYPH_COUNT - 1;

  logic                           code_ok;
  logic                           slot_ok;
  logic [7:0]                     code_eff;
  logic [ADDR_W-1:0]              base;
  logic [ADDR_W-1:0]              addr;
  logic signed [COORD_BITS-1:0]   x_c;
  logic signed [COORD_BITS-1:0]   y_c;

  always_comb begin
    code_ok  = {1'b0, char_code} < 9'(GLYPH_COUNT);
    slot_ok  = {1'b0, entry_slot} < 6'(ENTRIES_PER_GLYPH);
    code_eff = (command && !code_ok) ? 8'(REPL) : char_code;
    base     = ADDR_W'(code_eff) * ADDR_W'(ENTRIES_PER_GLYPH);
    addr     = command ? base : base + ADDR_W'(entry_slot);
    x_c      = COORD_BITS'(entry_x);
    y_c      = COORD_BITS'(entry_y);
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && (command || (code_ok && slot_ok));
  assign push_data  = {command, addr, entry_op, x_c, y_c, start_of_string};

endmodule

`default_nettype wire

// ===== design/sgs_queue.sv =====
// Short request queue between the front end and the glyph walker.
// Depends on sgs_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module sgs_queue
  import sgs_pkg::*;
#(
  parameter int QW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire logic [QW-1:0] push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output logic [QW-1:0]      pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [QW-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != (PW + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sgs_back.sv =====
// Back end: owns the glyph store, walks glyph entries and drives the event
// output register. Depends on sgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgs_back
  import sgs_pkg::*;
#(
  parameter int GLYPH_COUNT       = 128,
  parameter int ENTRIES_PER_GLYPH = 18,
  parameter int COORD_BITS        = 16,
  parameter int ADDR_W            = 12,
  parameter int QW                = 2 * COORD_BITS + ADDR_W + OP_W + 2
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [7:0]                default_advance,
  input  wire logic                      q_valid,
  output logic                           q_ready,
  input  wire logic [QW-1:0]             q_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [2:0]                     event_res,
  output logic signed [POINT_W-1:0]      point_x,
  output logic signed [POINT_W-1:0]      point_y,
  output logic signed [POINT_W-1:0]      advance,
  output logic signed [WIDTH_W-1:0]      width_total,
  output logic                           last
);

  localparam int DEPTH   = GLYPH_COUNT * ENTRIES_PER_GLYPH;
  localparam int ENTRY_W = OP_W + 2 * COORD_BITS;
  localparam int K_W     = (ENTRIES_PER_GLYPH > 1) ? $clog2(ENTRIES_PER_GLYPH) : 1;
  localparam int ADV_W   = (COORD_BITS > 9) ? COORD_BITS : 9;
  localparam int SUM_W   = ((ADV_W > WIDTH_W) ? ADV_W : WIDTH_W) + 1;
  localparam logic [K_W-1:0] K_LAST = K_W'(ENTRIES_PER_GLYPH - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(WIDTH_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(WIDTH_MIN);

  logic                          q_start;
  logic signed [COORD_BITS-1:0]  q_y;
  logic signed [COORD_BITS-1:0]  q_x;
  logic [OP_W-1:0]               q_op;
  logic [ADDR_W-1:0]             q_addr;
  logic                          q_render;

  assign q_start  = q_data[0];
  assign q_y      = q_data[COORD_BITS:1];
  assign q_x      = q_data[2*COORD_BITS:COORD_BITS+1];
  assign q_op     = q_data[2*COORD_BITS+OP_W:2*COORD_BITS+1];
  assign q_addr   = q_data[2*COORD_BITS+OP_W+ADDR_W:2*COORD_BITS+OP_W+1];
  assign q_render = q_data[QW-1];

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_entry;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;

  logic [OP_W-1:0]              rd_op;
  logic signed [COORD_BITS-1:0] rd_x;
  logic signed [COORD_BITS-1:0] rd_y;

  state_t                        state, state_next;
  logic [ADDR_W-1:0]             base, base_next;
  logic [K_W-1:0]                k, k_next;
  logic                          line_open, line_open_next;
  logic signed [ADV_W-1:0]       adv, adv_next;
  logic                          adv_found, adv_found_next;
  logic                          start_clr, start_clr_next;
  event_t                        ev_a, ev_a_next;
  event_t                        ev_b, ev_b_next;
  logic [1:0]                    ev_cnt, ev_cnt_next;
  logic                          ev_idx, ev_idx_next;
  logic                          stop, stop_next;
  logic signed [COORD_BITS-1:0]  px, px_next;
  logic signed [COORD_BITS-1:0]  py, py_next;
  logic signed [WIDTH_W-1:0]     running_width, running_width_next;

  logic                          emit_ok;
  logic                          emit;
  event_t                        emit_ev;
  logic signed [POINT_W-1:0]     emit_px;
  logic signed [POINT_W-1:0]     emit_py;
  logic signed [POINT_W-1:0]     emit_adv;
  logic signed [WIDTH_W-1:0]     emit_w;
  logic                          emit_last;
  logic signed [WIDTH_W-1:0]     rw_base;
  logic signed [SUM_W-1:0]       sum;
  logic signed [WIDTH_W-1:0]     sum_sat;

  assign rd_op   = rd_entry[ENTRY_W-1:2*COORD_BITS];
  assign rd_x    = rd_entry[2*COORD_BITS-1:COORD_BITS];
  assign rd_y    = rd_entry[COORD_BITS-1:0];
  assign rd_addr = base + ADDR_W'(k);
  assign emit_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_addr] <= {q_op, q_x, q_y};
    end
    rd_entry <= mem[rd_addr];
  end

  always_comb begin
    rw_base = start_clr ? '0 : running_width;
    sum     = SUM_W'(rw_base) + SUM_W'(adv);
    if (sum > SUM_MAX) begin
      sum_sat = WIDTH_W'(SUM_MAX);
    end else if (sum < SUM_MIN) begin
      sum_sat = WIDTH_W'(SUM_MIN);
    end else begin
      sum_sat = WIDTH_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next         = state;
    base_next          = base;
    k_next             = k;
    line_open_next     = line_open;
    adv_next           = adv;
    adv_found_next     = adv_found;
    start_clr_next     = start_clr;
    ev_a_next          = ev_a;
    ev_b_next          = ev_b;
    ev_cnt_next        = ev_cnt;
    ev_idx_next        = ev_idx;
    stop_next          = stop;
    px_next            = px;
    py_next            = py;
    running_width_next = running_width;
    q_ready            = 1'b0;
    mem_we             = 1'b0;
    emit               = 1'b0;
    emit_ev            = EV_DONE;
    emit_px            = '0;
    emit_py            = '0;
    emit_adv           = '0;
    emit_w             = '0;
    emit_last          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_render) begin
            base_next      = q_addr;
            k_next         = '0;
            line_open_next = 1'b0;
            adv_next       = ADV_W'({1'b0, default_advance});
            adv_found_next = 1'b0;
            start_clr_next = q_start;
            state_next     = ST_WAIT;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_WAIT: begin
        state_next = ST_ENTRY;
      end
      ST_ENTRY: begin
        ev_a_next   = EV_END_LINE;
        ev_b_next   = EV_END_LINE;
        ev_cnt_next = 2'd0;
        ev_idx_next = 1'b0;
        stop_next   = 1'b0;
        px_next     = rd_x;
        py_next     = rd_y;
        unique case (rd_op)
          OP_END: begin
            if (line_open) begin
              ev_cnt_next    = 2'd1;
              line_open_next = 1'b0;
            end
            stop_next = 1'b1;
          end
          OP_MOVE: begin
            if (line_open) begin
              ev_b_next   = EV_TRANSLATE;
              ev_cnt_next = 2'd2;
            end else begin
              ev_a_next   = EV_TRANSLATE;
              ev_cnt_next = 2'd1;
            end
            line_open_next = 1'b0;
            if (!adv_found) begin
              adv_next       = ADV_W'(rd_x);
              adv_found_next = 1'b1;
            end
          end
          OP_BEGIN: begin
            if (line_open) begin
              ev_b_next   = EV_BEGIN_LINE;
              ev_cnt_next = 2'd2;
            end else begin
              ev_a_next   = EV_BEGIN_LINE;
              ev_cnt_next = 2'd1;
            end
            line_open_next = 1'b1;
          end
          OP_VERTEX: begin
            if (line_open) begin
              ev_a_next   = EV_VERTEX;
              ev_cnt_next = 2'd1;
            end
          end
          OP_END_LINE: begin
            if (line_open) begin
              ev_a_next      = EV_VERTEX;
              ev_cnt_next    = 2'd2;
              line_open_next = 1'b0;
            end
          end
          default: begin
          end
        endcase
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if ({1'b0, ev_idx} < ev_cnt) begin
          if (emit_ok) begin
            emit        = 1'b1;
            emit_ev     = ev_idx ? ev_b : ev_a;
            if (emit_ev != EV_END_LINE) begin
              emit_px = POINT_W'(px);
              emit_py = POINT_W'(py);
            end
            ev_idx_next = 1'b1;
            if (ev_idx) begin
              ev_cnt_next = 2'd0;
            end
          end
        end else if (stop || k == K_LAST) begin
          state_next = ST_CLOSE;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_CLOSE: begin
        if (!line_open) begin
          state_next = ST_DONE;
        end else if (emit_ok) begin
          emit           = 1'b1;
          emit_ev        = EV_END_LINE;
          line_open_next = 1'b0;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (emit_ok) begin
          emit               = 1'b1;
          emit_ev            = EV_DONE;
          emit_adv           = POINT_W'(adv);
          emit_w             = sum_sat;
          emit_last          = 1'b1;
          running_width_next = sum_sat;
          state_next         = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_open     <= 1'b0;
      running_width <= '0;
      ev_cnt        <= 2'd0;
      ev_idx        <= 1'b0;
      stop          <= 1'b0;
      k             <= '0;
    end else begin
      line_open     <= line_open_next;
      running_width <= running_width_next;
      ev_cnt        <= ev_cnt_next;
      ev_idx        <= ev_idx_next;
      stop          <= stop_next;
      k             <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    base      <= base_next;
    adv       <= adv_next;
    adv_found <= adv_found_next;
    start_clr <= start_clr_next;
    ev_a      <= ev_a_next;
    ev_b      <= ev_b_next;
    px        <= px_next;
    py        <= py_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_res   <= emit_ev;
      point_x     <= emit_px;
      point_y     <= emit_py;
      advance     <= emit_adv;
      width_total <= emit_w;
      last        <= emit_last;
    end
  end

  a_idle_line_closed : assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !line_open)
    else $error("line left open between characters");

  a_last_on_done : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (event_res == EV_DONE)))
    else $error("last flag does not match the done event");

  a_event_count : assert property (@(posedge clk) disable iff (rst)
    ev_cnt != 2'd3)
    else $error("more than two events planned for one entry");

  a_walk_bound : assert property (@(posedge clk) disable iff (rst)
    k <= K_LAST)
    else $error("entry index ran past the glyph");

  a_emit_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("event register overwritten before it was taken");

endmodule

`default_nettype wire

// ===== design/stroke_glyph_sequencer_unit.sv =====
// Top level of the stroke glyph sequencer: configuration register, front end,
// request queue and glyph walker. Depends on sgs_pkg, sgs_front, sgs_queue, sgs_back.
//
// A load request writes one glyph entry once it reaches the head of the four-deep
// request queue while the walker is idle. A render request walks the glyph one
// entry at a time through a store with registered reads: for each entry the walker
// waits for the read, decodes the entry and emits the events it produces; it then
// closes any open line and delivers the done event. Output stalls hold the
// walker in its emit, close and done states. Requests keep being accepted
// into the queue while the walker is busy, until the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module stroke_glyph_sequencer_unit
  import sgs_pkg::*;
#(
  parameter int GLYPH_COUNT       = 128,
  parameter int ENTRIES_PER_GLYPH = 18,
  parameter int COORD_BITS        = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [7:0]                cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      command,
  input  wire logic [7:0]                char_code,
  input  wire logic [4:0]                entry_slot,
  input  wire logic [OP_W-1:0]           entry_op,
  input  wire logic signed [15:0]        entry_x,
  input  wire logic signed [15:0]        entry_y,
  input  wire logic                      start_of_string,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [2:0]                     event_res,
  output logic signed [POINT_W-1:0]      point_x,
  output logic signed [POINT_W-1:0]      point_y,
  output logic signed [POINT_W-1:0]      advance,
  output logic signed [WIDTH_W-1:0]      width_total,
  output logic                           last
);

  localparam int DEPTH  = GLYPH_COUNT * ENTRIES_PER_GLYPH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW     = 2 * COORD_BITS + ADDR_W + OP_W + 2;

  logic [7:0]    default_advance;
  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          q_valid;
  logic          q_ready;
  logic [QW-1:0] q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_advance <= 8'(RESET_ADVANCE);
    end else if (cfg_we) begin
      default_advance <= cfg_data;
    end
  end

  sgs_front #(
    .GLYPH_COUNT       (GLYPH_COUNT),
    .ENTRIES_PER_GLYPH (ENTRIES_PER_GLYPH),
    .COORD_BITS        (COORD_BITS),
    .ADDR_W            (ADDR_W),
    .QW                (QW)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .char_code       (char_code),
    .entry_slot      (entry_slot),
    .entry_op        (entry_op),
    .entry_x         (entry_x),
    .entry_y         (entry_y),
    .start_of_string (start_of_string),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  sgs_queue #(
    .QW (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  sgs_back #(
    .GLYPH_COUNT       (GLYPH_COUNT),
    .ENTRIES_PER_GLYPH (ENTRIES_PER_GLYPH),
    .COORD_BITS        (COORD_BITS),
    .ADDR_W            (ADDR_W),
    .QW                (QW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .default_advance (default_advance),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_data          (q_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_res       (event_res),
    .point_x         (point_x),
    .point_y         (point_y),
    .advance         (advance),
    .width_total     (width_total),
    .last            (last)
  );

endmodule

`default_nettype wire

// ===== tb/sv/glyph_tb_pkg.sv =====
// Command codes and glyph store geometry shared by the sequencer testbench files.
// No dependencies.
`timescale 1ns / 1ps

package glyph_tb_pkg;

  localparam int TB_GLYPHS  = 128;
  localparam int TB_ENTRIES = 18;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  localparam logic [7:0] OP_UNKNOWN_LO = 8'd5;
  localparam logic [7:0] OP_UNKNOWN_HI = 8'd255;

endpackage

// ===== tb/sv/glyph_event_checker.sv =====
// Watches the request, configuration and event channels of the stroke glyph sequencer,
// predicts the drawing events of every render request and compares them in order.
// Depends on sgs_pkg and glyph_tb_pkg.
`timescale 1ns / 1ps

module glyph_event_checker
  import sgs_pkg::*;
  import glyph_tb_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [7:0]               cfg_data,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic                     command,
  input  wire logic [7:0]               char_code,
  input  wire logic [4:0]               entry_slot,
  input  wire logic [OP_W-1:0]          entry_op,
  input  wire logic signed [15:0]       entry_x,
  input  wire logic signed [15:0]       entry_y,
  input  wire logic                     start_of_string,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic [2:0]               event_res,
  input  wire logic signed [POINT_W-1:0] point_x,
  input  wire logic signed [POINT_W-1:0] point_y,
  input  wire logic signed [POINT_W-1:0] advance,
  input  wire logic signed [WIDTH_W-1:0] width_total,
  input  wire logic                     last,
  output int                            failures,
  output int                            pending,
  output int                            checked
);

  typedef struct {
    event_t                     ev;
    logic signed [POINT_W-1:0]  px;
    logic signed [POINT_W-1:0]  py;
    logic signed [POINT_W-1:0]  adv;
    logic signed [WIDTH_W-1:0]  total;
    logic                       fin;
  } glyph_event_t;

  logic [OP_W-1:0]           op_store [TB_GLYPHS*TB_ENTRIES];
  logic signed [POINT_W-1:0] x_store  [TB_GLYPHS*TB_ENTRIES];
  logic signed [POINT_W-1:0] y_store  [TB_GLYPHS*TB_ENTRIES];
  logic [7:0]                advance_default;
  int                        string_width;
  int                        fail_count = 0;
  int                        event_count = 0;
  glyph_event_t              expected_events[$];

  function automatic void queue_event(event_t ev, logic signed [POINT_W-1:0] px,
                                      logic signed [POINT_W-1:0] py,
                                      logic signed [POINT_W-1:0] adv,
                                      logic signed [WIDTH_W-1:0] total, logic fin);
    glyph_event_t e;
    e.ev = ev;
    e.px = px;
    e.py = py;
    e.adv = adv;
    e.total = total;
    e.fin = fin;
    expected_events.push_back(e);
  endfunction

  function automatic void predict_render(logic [7:0] code, logic sos);
    int base;
    bit open, stopped, found;
    logic [OP_W-1:0] op;
    logic signed [POINT_W-1:0] px, py, adv;
    base = (code >= TB_GLYPHS ? REPLACE_CODE : int'(code)) * TB_ENTRIES;
    open = 1'b0;
    stopped = 1'b0;
    found = 1'b0;
    if (op_store[base] != OP_END) begin
      for (int k = 0; k < TB_ENTRIES && !stopped; k++) begin
        op = op_store[base+k];
        px = x_store[base+k];
        py = y_store[base+k];
        case (op)
          OP_END: begin
            if (open) queue_event(EV_END_LINE, 0, 0, 0, 0, 1'b0);
            open = 1'b0;
            stopped = 1'b1;
          end
          OP_MOVE: begin
            if (open) queue_event(EV_END_LINE, 0, 0, 0, 0, 1'b0);
            open = 1'b0;
            queue_event(EV_TRANSLATE, px, py, 0, 0, 1'b0);
          end
          OP_BEGIN: begin
            if (open) queue_event(EV_END_LINE, 0, 0, 0, 0, 1'b0);
            queue_event(EV_BEGIN_LINE, px, py, 0, 0, 1'b0);
            open = 1'b1;
          end
          OP_VERTEX: begin
            if (open) queue_event(EV_VERTEX, px, py, 0, 0, 1'b0);
          end
          OP_END_LINE: begin
            if (open) begin
              queue_event(EV_VERTEX, px, py, 0, 0, 1'b0);
              queue_event(EV_END_LINE, 0, 0, 0, 0, 1'b0);
              open = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      // A line still open after the last entry is closed here.
      if (open) queue_event(EV_END_LINE, 0, 0, 0, 0, 1'b0);
    end
    adv = {8'd0, advance_default};
    for (int k = 0; k < TB_ENTRIES && !found && op_store[base+k] != OP_END; k++) begin
      if (op_store[base+k] == OP_MOVE) begin
        adv = x_store[base+k];
        found = 1'b1;
      end
    end
    if (sos) string_width = 0;
    string_width = string_width + int'(adv);
    if (string_width > WIDTH_MAX) string_width = WIDTH_MAX;
    if (string_width < WIDTH_MIN) string_width = WIDTH_MIN;
    queue_event(EV_DONE, 0, 0, adv, string_width[WIDTH_W-1:0], 1'b1);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] actual,
                                      logic signed [31:0] wanted);
    if (actual !== wanted) begin
      $error("%s: expected %0d, got %0d", name, wanted, actual);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    glyph_event_t want;
    int addr;
    if (rst) begin
      advance_default = 8'(RESET_ADVANCE);
      string_width = 0;
      expected_events.delete();
    end else begin
      if (cfg_we) advance_default = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("event %0d arrived with nothing expected", event_res);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", event_res, want.ev);
          check_field("point_x", point_x, want.px);
          check_field("point_y", point_y, want.py);
          check_field("advance", advance, want.adv);
          check_field("width_total", width_total, want.total);
          check_field("last", last, want.fin);
          event_count++;
        end
      end
      if (in_valid && in_ready) begin
        if (command == CMD_RENDER) begin
          predict_render(char_code, start_of_string);
        end else if (char_code < TB_GLYPHS && entry_slot < TB_ENTRIES) begin
          addr = int'(char_code) * TB_ENTRIES + int'(entry_slot);
          op_store[addr] = entry_op;
          x_store[addr] = entry_x;
          y_store[addr] = entry_y;
        end
      end
    end
    failures <= fail_count;
    pending <= expected_events.size();
    checked <= event_count;
  end

endmodule

// ===== tb/sv/stroke_glyph_sequencer_unit_tb.sv =====
// Top of the stroke glyph sequencer testbench: clock, reset, request and event
// stimulus with random idling, and the verdict. Depends on sgs_pkg, glyph_tb_pkg,
// glyph_event_checker and the stroke_glyph_sequencer_unit design.
`timescale 1ns / 1ps

module stroke_glyph_sequencer_unit_tb;
  import sgs_pkg::*;
  import glyph_tb_pkg::*;

  localparam int RANDOM_ITEMS = 72;
  localparam int SAT_RENDERS  = 258;
  localparam int DRAIN_CYCLES = 20;
  localparam int END_CYCLES   = 100;
  localparam logic [7:0] SAT_UP_GLYPH   = 8'd3;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic command;
  logic [7:0] char_code;
  logic [4:0] entry_slot;
  logic [OP_W-1:0] entry_op;
  logic signed [15:0] entry_x;
  logic signed [15:0] entry_y;
  logic start_of_string;
  logic out_valid;
  logic out_ready;
  logic [2:0] event_res;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic signed [POINT_W-1:0] advance;
  logic signed [WIDTH_W-1:0] width_total;
  logic last;

  int mismatch_count;
  int events_pending;
  int events_checked;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int counted_items = 0;
  int loads_sent = 0;
  int renders_sent = 0;
  logic [OP_W-1:0] shadow_op [TB_GLYPHS*TB_ENTRIES];
  bit shadow_written [TB_GLYPHS*TB_ENTRIES];

  stroke_glyph_sequencer_unit #(
    .GLYPH_COUNT      (TB_GLYPHS),
    .ENTRIES_PER_GLYPH(TB_ENTRIES),
    .COORD_BITS       (16)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .char_code      (char_code),
    .entry_slot     (entry_slot),
    .entry_op       (entry_op),
    .entry_x        (entry_x),
    .entry_y        (entry_y),
    .start_of_string(start_of_string),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .point_x        (point_x),
    .point_y        (point_y),
    .advance        (advance),
    .width_total    (width_total),
    .last           (last)
  );

  glyph_event_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .char_code      (char_code),
    .entry_slot     (entry_slot),
    .entry_op       (entry_op),
    .entry_x        (entry_x),
    .entry_y        (entry_y),
    .start_of_string(start_of_string),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .point_x        (point_x),
    .point_y        (point_y),
    .advance        (advance),
    .width_total    (width_total),
    .last           (last),
    .failures       (mismatch_count),
    .pending        (events_pending),
    .checked        (events_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  // A render request is only sent when every entry its walk reads has been loaded.
  function automatic bit glyph_ready(int g);
    for (int k = 0; k < TB_ENTRIES; k++) begin
      if (!shadow_written[g*TB_ENTRIES+k]) return 1'b0;
      if (shadow_op[g*TB_ENTRIES+k] == OP_END) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic bit code_ready(logic [7:0] code);
    return glyph_ready(code >= TB_GLYPHS ? REPLACE_CODE : int'(code));
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return OP_MOVE;
    if (r < 40) return OP_BEGIN;
    if (r < 70) return OP_VERTEX;
    if (r < 85) return OP_END_LINE;
    if (r < 95) return 8'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
    return OP_END;
  endfunction

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(logic cmd, logic [7:0] code, logic [4:0] slot,
                              logic [OP_W-1:0] op, logic signed [15:0] x,
                              logic signed [15:0] y, logic sos);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command = cmd;
    char_code = code;
    entry_slot = slot;
    entry_op = op;
    entry_x = x;
    entry_y = y;
    start_of_string = sos;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_entry(logic [7:0] g, logic [4:0] slot, logic [OP_W-1:0] op,
                            logic signed [15:0] x, logic signed [15:0] y);
    send_request(CMD_LOAD, g, slot, op, x, y, 1'($urandom));
    loads_sent++;
    if (g < TB_GLYPHS && slot < TB_ENTRIES) begin
      shadow_op[int'(g)*TB_ENTRIES+int'(slot)] = op;
      shadow_written[int'(g)*TB_ENTRIES+int'(slot)] = 1'b1;
      counted_items++;
    end
  endtask

  task automatic render_char(logic [7:0] code, logic sos);
    send_request(CMD_RENDER, code, 5'($urandom), 8'($urandom), 16'($urandom),
                 16'($urandom), sos);
    renders_sent++;
    counted_items++;
  endtask

  task automatic hold_until_quiet();
    in_valid = 1'b0;
    while (events_pending != 0) @(negedge clk);
  endtask

  // Loads give no events, so an extra drain wait lets queued loads finish first.
  task automatic set_default_advance(logic [7:0] value);
    hold_until_quiet();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic redraw_idling();
    tx_idle_on = ($urandom_range(0, 2) != 0);
    rx_idle_on = ($urandom_range(0, 2) != 0);
  endtask

  task automatic random_step();
    int unsigned pick;
    int unsigned len;
    logic [7:0] g;
    logic [7:0] code;
    bit found;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 29) == 0) redraw_idling();
    if (pick < 35) begin
      g = 8'($urandom_range(0, TB_GLYPHS - 1));
      len = $urandom_range(1, TB_ENTRIES);
      for (int s = 0; s < len; s++) load_entry(g, 5'(s), pick_op(), pick_coord(), pick_coord());
      if (len < TB_ENTRIES) begin
        load_entry(g, 5'(len), OP_END, pick_coord(), pick_coord());
      end else if ($urandom_range(0, 1) == 1) begin
        load_entry(g, 5'(TB_ENTRIES - 1), OP_BEGIN, pick_coord(), pick_coord());
      end
      repeat ($urandom_range(1, 3)) begin
        code = (g == REPLACE_CODE && $urandom_range(0, 1) == 1) ?
               8'($urandom_range(TB_GLYPHS, 255)) : g;
        render_char(code, $urandom_range(0, 7) == 0);
      end
    end else if (pick < 80) begin
      found = 1'b0;
      repeat (8) begin
        if (!found) begin
          code = 8'($urandom);
          found = code_ready(code);
        end
      end
      if (found) render_char(code, $urandom_range(0, 7) == 0);
    end else if (pick < 90) begin
      load_entry(8'($urandom_range(0, TB_GLYPHS - 1)), 5'($urandom_range(0, TB_ENTRIES - 1)),
                 8'($urandom), pick_coord(), pick_coord());
    end else if (pick < 95) begin
      if ($urandom_range(0, 1) == 1) begin
        load_entry(8'($urandom_range(TB_GLYPHS, 255)), 5'($urandom), 8'($urandom),
                   16'($urandom), 16'($urandom));
      end else begin
        load_entry(8'($urandom), 5'($urandom_range(TB_ENTRIES, 31)), 8'($urandom),
                   16'($urandom), 16'($urandom));
      end
    end else begin
      hold_until_quiet();
    end
  endtask

  initial begin : receiver
    int unsigned stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int target;
    logic [7:0] phase_advance [4];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_LOAD;
    char_code = '0;
    entry_slot = '0;
    entry_op = OP_END;
    entry_x = '0;
    entry_y = '0;
    start_of_string = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // The replacement glyph draws a full line with coordinates at both extremes.
    load_entry(8'(REPLACE_CODE), 5'd0, OP_MOVE, 16'sh7FFF, 16'sh8000);
    load_entry(8'(REPLACE_CODE), 5'd1, OP_BEGIN, 16'sh8000, 16'sh7FFF);
    load_entry(8'(REPLACE_CODE), 5'd2, OP_VERTEX, -16'sd1, 16'sd0);
    load_entry(8'(REPLACE_CODE), 5'd3, OP_END_LINE, 16'sh1234, -16'sh1234);
    load_entry(8'(REPLACE_CODE), 5'd4, OP_END, 16'sd0, 16'sd0);
    load_entry(8'd0, 5'd0, OP_END, 16'sd5, 16'sd5);
    load_entry(8'd1, 5'd0, OP_BEGIN, 16'sd100, -16'sd100);
    load_entry(8'd1, 5'd1, OP_VERTEX, 16'sd200, 16'sd300);
    load_entry(8'd1, 5'd2, OP_END, 16'sd0, 16'sd0);
    load_entry(8'd2, 5'd0, OP_VERTEX, 16'sd1, 16'sd2);
    load_entry(8'd2, 5'd1, OP_END_LINE, 16'sd3, 16'sd4);
    load_entry(8'd2, 5'd2, OP_UNKNOWN_LO, 16'sd5, 16'sd6);
    load_entry(8'd2, 5'd3, OP_UNKNOWN_HI, 16'sd7, 16'sd8);
    load_entry(8'd2, 5'd4, OP_BEGIN, -16'sd9, 16'sd10);
    load_entry(8'd2, 5'd5, OP_BEGIN, 16'sd11, -16'sd12);
    load_entry(8'd2, 5'd6, OP_MOVE, 16'sh8000, 16'sd13);
    load_entry(8'd2, 5'd7, OP_END, 16'sd0, 16'sd0);
    load_entry(8'd200, 5'd0, OP_MOVE, 16'sd77, 16'sd77);
    load_entry(8'd5, 5'd31, OP_MOVE, 16'sd77, 16'sd77);
    render_char(8'(REPLACE_CODE), 1'b1);
    render_char(8'd200, 1'b0);
    render_char(8'd0, 1'b0);
    render_char(8'd1, 1'b0);
    render_char(8'd2, 1'b0);
    render_char(8'd255, 1'b1);

    phase_advance[0] = 8'd0;
    phase_advance[1] = 8'($urandom);
    phase_advance[2] = 8'd255;
    phase_advance[3] = 8'($urandom);
    target = counted_items;
    for (int p = 0; p < 4; p++) begin
      set_default_advance(phase_advance[p]);
      redraw_idling();
      if (p == 0) hold_until_quiet();
      target = target + RANDOM_ITEMS / 4;
      while (counted_items < target) random_step();
    end

    // A long string of the widest glyph drives the running width into its upper limit.
    set_default_advance(8'($urandom));
    load_entry(SAT_UP_GLYPH, 5'd0, OP_MOVE, 16'sh7FFF, 16'sd0);
    load_entry(SAT_UP_GLYPH, 5'd1, OP_END, 16'sd0, 16'sd0);
    for (int i = 0; i < SAT_RENDERS; i++) begin
      if (i % 50 == 0) redraw_idling();
      render_char(SAT_UP_GLYPH, i == 0);
    end

    hold_until_quiet();
    repeat (END_CYCLES) @(negedge clk);
    $display("Sent %0d glyph loads and %0d characters over several advance settings,",
             loads_sent, renders_sent);
    $display("and compared %0d drawing events, including width saturation at the top.",
             events_checked);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sgs_pkg.sv
design/sgs_front.sv
design/sgs_queue.sv
design/sgs_back.sv
design/stroke_glyph_sequencer_unit.sv
tb/sv/glyph_tb_pkg.sv
tb/sv/glyph_event_checker.sv
tb/sv/stroke_glyph_sequencer_unit_tb.sv
